// ----- rtl/ifp_pkg.sv -----
package ifp_pkg;

  // Packed widths of the stream payloads.
  localparam int InDataW  = 72;
  localparam int OutDataW = 80;
  localparam int OutUserW = 3;

  // Smallest payload slice that a fragment can carry, and the 8-byte grid mask.
  localparam logic [15:0] ChunkMin  = 16'd8;
  localparam logic [15:0] ChunkMask = 16'hFFF8;

  // Result status codes carried in tuser.
  typedef enum logic [2:0] {
    ST_WHOLE     = 3'd0,
    ST_FRAG      = 3'd1,
    ST_NO_ROUTE  = 3'd2,
    ST_BCAST_BIG = 3'd3,
    ST_DF_DROP   = 3'd4,
    ST_MTU_SMALL = 3'd5,
    ST_TOO_MANY  = 3'd6
  } ifp_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture an accepted descriptor
    logic prep;     // work out payload, slice size and early decisions
    logic check;    // fragment count limit, clear the position
    logic advance;  // a result transfer completed, step to the next slice
  } ifp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_last; // the result on offer is the final one for this packet
  } ifp_sts_t;

endpackage

// ----- rtl/ipv4_fragment_planner.sv -----
// Channel   Dir  Transfer when               Content
// s_axis    in   s_axis_tvalid & tready      one outgoing packet descriptor
// m_axis    out  m_axis_tvalid & tready      one result: whole, fragment or drop
//
// A packet is taken in S_IDLE, then S_PREP and S_CHECK decide it; results follow
// at one per cycle while the result side does not stall, N of them with N from 1 to
// MAX_FRAGMENTS, set by the slice position register stepping once per result.
// Reset clears the controller and the packet id counter; nothing else.
// A stall on the result side holds the offered result and the block stays busy.
module ipv4_fragment_planner #(
  parameter int HEADER_BYTES  = 20,
  parameter int MAX_FRAGMENTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // total_len[15:0], offset_in[28:16], more_in[29], dont_frag[30], forwarding[31],
  // route_found[32], is_broadcast[33], link_mtu[49:34], id_in[65:50], zero[71:66]
  input  logic [ifp_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // packet_id[15:0], frag_offset[28:16], more_frags[29], df_out[30], out_len[46:31],
  // payload_start[62:47], payload_len[78:63], zero[79]
  output logic [ifp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // status[2:0]
  output logic [ifp_pkg::OutUserW-1:0]  m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);
  import ifp_pkg::*;

  ifp_cmd_t cmd;
  ifp_sts_t sts;

  // Sequencing of one packet.
  ifp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .m_axis_tready_i (m_axis_tready_i),
    .sts_i           (sts),
    .cmd_o           (cmd),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tvalid_o (m_axis_tvalid_o)
  );

  // Decision and fragment arithmetic.
  ifp_dp #(
    .HEADER_BYTES  (HEADER_BYTES),
    .MAX_FRAGMENTS (MAX_FRAGMENTS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .s_tdata_i (s_axis_tdata_i),
    .m_tdata_o (m_axis_tdata_o),
    .m_tuser_o (m_axis_tuser_o),
    .m_tlast_o (m_axis_tlast_o)
  );

endmodule

// ----- rtl/ifp_ctrl.sv -----
module ifp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  input  logic              m_axis_tready_i,
  input  ifp_pkg::ifp_sts_t sts_i,
  output ifp_pkg::ifp_cmd_t cmd_o,
  output logic              s_axis_tready_o,
  output logic              m_axis_tvalid_o
);
  import ifp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PREP  = 4'b0010,
    S_CHECK = 4'b0100,
    S_EMIT  = 4'b1000
  } ifp_state_e;

  ifp_state_e state_q, state_d;
  logic       in_xfer;
  logic       out_xfer;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_EMIT);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer        = m_axis_tvalid_o && m_axis_tready_i;

  // Commands follow directly from the state and the handshakes.
  assign cmd_o.load    = in_xfer;
  assign cmd_o.prep    = (state_q == S_PREP);
  assign cmd_o.check   = (state_q == S_CHECK);
  assign cmd_o.advance = out_xfer;

  // Next-state logic: one packet at a time, results offered until the final one.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_PREP;
      end
      S_PREP:  state_d = S_CHECK;
      S_CHECK: state_d = S_EMIT;
      S_EMIT: begin
        if (out_xfer && sts_i.out_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/ifp_dp.sv -----
module ifp_dp #(
  parameter int HEADER_BYTES  = 20,
  parameter int MAX_FRAGMENTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ifp_pkg::ifp_cmd_t             cmd_i,
  output ifp_pkg::ifp_sts_t             sts_o,
  input  logic [ifp_pkg::InDataW-1:0]   s_tdata_i,
  output logic [ifp_pkg::OutDataW-1:0]  m_tdata_o,
  output logic [ifp_pkg::OutUserW-1:0]  m_tuser_o,
  output logic                          m_tlast_o
);
  import ifp_pkg::*;

  localparam logic [15:0] HdrLen = 16'(HEADER_BYTES);
  localparam int CntW  = $clog2(MAX_FRAGMENTS + 1);
  localparam int ProdW = 16 + CntW;
  localparam logic [CntW-1:0] MaxFrag = CntW'(MAX_FRAGMENTS);

  // Fields of the incoming descriptor.
  logic [15:0] in_total;
  logic [12:0] in_offset;
  logic        in_more;
  logic        in_df;
  logic        in_fwd;
  logic        in_route;
  logic        in_bcast;
  logic [15:0] in_mtu;
  logic [15:0] in_id;

  assign in_total  = s_tdata_i[15:0];
  assign in_offset = s_tdata_i[28:16];
  assign in_more   = s_tdata_i[29];
  assign in_df     = s_tdata_i[30];
  assign in_fwd    = s_tdata_i[31];
  assign in_route  = s_tdata_i[32];
  assign in_bcast  = s_tdata_i[33];
  assign in_mtu    = s_tdata_i[49:34];
  assign in_id     = s_tdata_i[65:50];

  logic [15:0] next_id_q;
  logic [15:0] total_q, mtu_q, id_q;
  logic [12:0] offin_q;
  logic        morein_q, df_q, route_q, bcast_q;
  logic [15:0] payload_q, chunk_q, pos_q;
  ifp_status_e status_q;

  // The id counter advances for every local packet, dropped or not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q <= '0;
    end else if (cmd_i.load && !in_fwd) begin
      next_id_q <= next_id_q + 16'd1;
    end
  end

  // Payload size and slice size, taken from the captured descriptor.
  logic [15:0] payload_c, chunk_c;
  ifp_status_e prep_status_c;

  assign payload_c = (total_q > HdrLen) ? (total_q - HdrLen) : '0;
  assign chunk_c   = (mtu_q > HdrLen) ? ((mtu_q - HdrLen) & ChunkMask) : '0;

  // Decisions in their order of priority, all but the fragment count.
  always_comb begin
    if (!route_q) begin
      prep_status_c = ST_NO_ROUTE;
    end else if (bcast_q && (total_q > mtu_q)) begin
      prep_status_c = ST_BCAST_BIG;
    end else if (total_q <= mtu_q) begin
      prep_status_c = ST_WHOLE;
    end else if (df_q) begin
      prep_status_c = ST_DF_DROP;
    end else if (chunk_c < ChunkMin) begin
      prep_status_c = ST_MTU_SMALL;
    end else begin
      prep_status_c = ST_FRAG;
    end
  end

  // More than the limit of fragments means payload above limit times slice size.
  logic [ProdW-1:0] frag_cap;
  logic             too_many;

  assign frag_cap = ProdW'(chunk_q) * ProdW'(MaxFrag);
  assign too_many = (ProdW'(payload_q) > frag_cap);

  // Current slice.
  logic [16:0] pos_end;
  logic        slice_final;
  logic [15:0] slice_len;

  assign pos_end     = {1'b0, pos_q} + {1'b0, chunk_q};
  assign slice_final = (pos_end >= {1'b0, payload_q});
  assign slice_len   = slice_final ? (payload_q - pos_q) : chunk_q;

  // Descriptor capture and per-packet working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      total_q  <= in_total;
      mtu_q    <= in_mtu;
      df_q     <= in_df;
      route_q  <= in_route;
      bcast_q  <= in_bcast;
      id_q     <= in_fwd ? in_id : next_id_q;
      offin_q  <= in_fwd ? in_offset : '0;
      morein_q <= in_fwd && in_more;
    end
    if (cmd_i.prep) begin
      payload_q <= payload_c;
      chunk_q   <= chunk_c;
      status_q  <= prep_status_c;
    end
    if (cmd_i.check) begin
      pos_q <= '0;
      if ((status_q == ST_FRAG) && too_many) status_q <= ST_TOO_MANY;
    end else if (cmd_i.advance) begin
      pos_q <= pos_end[15:0];
    end
  end

  // Result fields for the item on offer.
  logic [12:0] r_offset;
  logic        r_more, r_df, r_last;
  logic [15:0] r_len, r_pstart, r_plen;

  always_comb begin
    r_offset = '0;
    r_more   = 1'b0;
    r_df     = 1'b0;
    r_len    = '0;
    r_pstart = '0;
    r_plen   = '0;
    r_last   = 1'b1;
    case (status_q)
      ST_WHOLE: begin
        r_offset = offin_q;
        r_more   = morein_q;
        r_df     = df_q;
        r_len    = total_q;
        r_plen   = payload_q;
      end
      ST_FRAG: begin
        r_offset = offin_q + pos_q[15:3];
        r_more   = slice_final ? morein_q : 1'b1;
        r_len    = slice_len + HdrLen;
        r_pstart = pos_q;
        r_plen   = slice_len;
        r_last   = slice_final;
      end
      default: begin
        r_last = 1'b1;
      end
    endcase
  end

  assign m_tdata_o      = {1'b0, r_plen, r_pstart, r_len, r_df, r_more, r_offset, id_q};
  assign m_tuser_o      = status_q;
  assign m_tlast_o      = r_last;
  assign sts_o.out_last = r_last;

endmodule

// ----- rtl/ifp_checker.sv -----
module ifp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [ifp_pkg::InDataW-1:0]   s_axis_tdata_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [ifp_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic [ifp_pkg::OutUserW-1:0]  m_axis_tuser_o,
  input logic                          m_axis_tlast_o
);
  import ifp_pkg::*;

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("result changed while stalled");

  // Only one packet is in work: no input is taken while results are on offer.
  a_one_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a result is offered");

  // An accepted packet keeps the input closed in the following cycle.
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready right after a transfer");

  // After the final result the output side goes quiet.
  a_end_of_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o) |=> !m_axis_tvalid_o)
    else $error("result offered after the final one");

  // Only fragments come in runs of more than one result.
  a_run_is_frag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> (m_axis_tuser_o == ST_FRAG))
    else $error("non-final result that is not a fragment");

endmodule

bind ipv4_fragment_planner ifp_checker u_ifp_checker (.*);
